[hw/rtl/line_waypoint_generator_macros.svh]
// assertion macros used by the checker file lwg_checker.sv
`ifndef LINE_WAYPOINT_GENERATOR_MACROS_SVH
`define LINE_WAYPOINT_GENERATOR_MACROS_SVH
// implication checked every clock outside reset
`define LWG_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication checked outside reset
`define LWG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

[hw/rtl/lwg_pkg.sv]
// types and constants of the waypoint generator
package lwg_pkg;
   typedef struct packed {
      logic signed [23:0] start_x;
      logic signed [23:0] start_y;
      logic signed [23:0] target_x;
      logic signed [23:0] target_y;
   } req_type;

   typedef struct packed {
      logic signed [23:0] point_x;
      logic signed [23:0] point_y;
      logic signed [15:0] heading;
      logic               is_last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQRT, ST_QUAD, ST_CORDIC, ST_ROUND,
      ST_CNT, ST_PMUL, ST_PDIV, ST_PADD, ST_EMIT
   } state_type;

   localparam int            HALF_PI_Q16 = 102944;
   localparam int            HEADING_MAX = 25736;

   function automatic logic [16:0] atan_q16(input logic [3:0] i);
      logic [16:0] r;
      begin
         case (i)
            4'd0: r = 17'd51472;  4'd1: r = 17'd30385;
            4'd2: r = 17'd16055;  4'd3: r = 17'd8150;
            4'd4: r = 17'd4091;   4'd5: r = 17'd2047;
            4'd6: r = 17'd1024;   4'd7: r = 17'd512;
            4'd8: r = 17'd256;    4'd9: r = 17'd128;
            4'd10: r = 17'd64;    4'd11: r = 17'd32;
            4'd12: r = 17'd16;    4'd13: r = 17'd8;
            4'd14: r = 17'd4;     default: r = 17'd2;
         endcase
         return r;
      end
   endfunction
endpackage

[hw/rtl/lwg_divider.sv]
// restoring divider, one quotient bit per cycle
module lwg_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [47:0] dividend,
   input  logic [24:0] divisor,
   output logic        done,
   output logic [47:0] quotient
);
   import lwg_pkg::*;
   logic [47:0] quot_ff, quot_in;
   logic [25:0] rem_ff, rem_in;
   logic [24:0] div_ff, div_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in, done_ff, done_in;
   logic [25:0] trial;
   logic [26:0] diff;

   always_comb begin
      quot_in = quot_ff; rem_in = rem_ff; div_in = div_ff;
      cnt_in = cnt_ff; run_in = run_ff; done_in = 1'b0;
      trial = {rem_ff[24:0], quot_ff[47]};
      diff = {1'b0, trial} - {2'b0, div_ff};
      if (go) begin
         quot_in = dividend; rem_in = '0; div_in = divisor;
         cnt_in = 6'd0; run_in = 1'b1;
      end else if (run_ff) begin
         if (!diff[26]) begin
            rem_in = diff[25:0];
            quot_in = {quot_ff[46:0], 1'b1};
         end else begin
            rem_in = trial;
            quot_in = {quot_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd47) begin
            run_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         run_ff <= run_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      quot_ff <= quot_in; rem_ff <= rem_in; div_ff <= div_in;
   end

   assign done = done_ff;
   assign quotient = quot_ff;
endmodule

[hw/rtl/line_waypoint_generator.sv]
// top level of the linear waypoint generator
// Usage: pulse start with a request on req_data while busy is low; the request
// is taken at that edge and busy rises. The block forms dx, dy, the distance by
// a bit-pair square root, the heading by a 16-step CORDIC with the quadrant fold
// and rounding, and the waypoint count on a 48-step restoring divider. Each
// intermediate waypoint needs, per axis, a 25-step shift-add multiply and a
// rounded 48-step divide; the final target point follows directly.
// Results appear on rsp_data for one cycle with rsp_valid; the receiver cannot
// stall, so nothing waits. With count n the final point (is_last) follows the n
// intermediate points; the count and every per-axis divide share one divider.
// busy falls as the final point is shown, so a new request may be taken in
// that cycle. The step length register step_ff is written from csr_wdata with
// csr_we; the user must do so only while idle, as the block itself does not
// enforce it. Reset loads 1.5 m and returns to idle.
module line_waypoint_generator #(
   parameter int MAX_WAYPOINTS = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  lwg_pkg::req_type req_data,
   output logic            rsp_valid,
   output lwg_pkg::rsp_type rsp_data,
   input  logic            csr_we,
   input  logic [15:0]     csr_wdata
);
   import lwg_pkg::*;
   localparam int CW = $clog2(MAX_WAYPOINTS);
   localparam logic [CW-1:0] CMAX = CW'(MAX_WAYPOINTS - 1);

   state_type state_ff, state_in;
   logic [15:0] step_ff;
   logic signed [24:0] sx_ff, sy_ff, dx_ff, dy_ff;
   logic signed [23:0] tx_ff, ty_ff;
   // square root
   logic [49:0] rad_ff;
   logic [25:0] root_ff, rem_ff;
   logic [4:0]  k_ff;
   // cordic
   logic signed [27:0] cx_ff, cy_ff;
   logic signed [19:0] cz_ff;
   logic [3:0]  ci_ff;
   logic signed [15:0] hd_ff;
   // waypoint loop
   logic [CW-1:0] cnt_ff, idx_ff;
   logic          axis_ff;
   logic [46:0] acc_ff;
   logic [4:0]  mb_ff;
   logic [46:0] mcand_ff;
   logic [24:0] mplr_ff;
   logic        neg_ff;
   logic signed [24:0] ox_ff;
   logic        div_go;
   logic        div_done;
   logic [47:0] div_q;
   logic [47:0] div_n;
   logic [24:0] div_d;
   logic [26:0] sq_trial;
   logic signed [27:0] xs, ys;
   logic signed [19:0] z_r;
   logic signed [16:0] h_r;
   logic [24:0] absd;

   lwg_divider u_div (
      .clock(clock), .reset(reset), .go(div_go), .dividend(div_n),
      .divisor(div_d), .done(div_done), .quotient(div_q)
   );

   assign busy = (state_ff != ST_IDLE);
   assign sq_trial = {rem_ff[24:0], rad_ff[49:48]} - {root_ff[24:0], 2'b01};
   assign xs = cx_ff >>> ci_ff;
   assign ys = cy_ff >>> ci_ff;
   assign z_r = (cz_ff + 20'sd4) >>> 3;
   assign h_r = (z_r > 20'(HEADING_MAX)) ? 17'(HEADING_MAX) :
                (z_r < -20'(HEADING_MAX)) ? -17'(HEADING_MAX) : z_r[16:0];
   assign absd = axis_ff ? (dy_ff[24] ? -dy_ff : dy_ff)
                         : (dx_ff[24] ? -dx_ff : dx_ff);

   always_comb begin
      state_in = state_ff;
      div_go = 1'b0; div_n = '0; div_d = root_ff[24:0];
      unique case (state_ff)
         ST_IDLE: if (start) state_in = ST_SQRT;
         ST_SQRT: if (k_ff == 5'd25) state_in = ST_QUAD;
         ST_QUAD: state_in = ST_CORDIC;
         ST_CORDIC: if (ci_ff == 4'd15) state_in = ST_ROUND;
         ST_ROUND: begin
            state_in = ST_CNT;
            div_go = (step_ff != 16'd0);
            div_n = {23'd0, root_ff[24:0]};
            div_d = {9'd0, step_ff};
         end
         ST_CNT: if (step_ff == 16'd0 || div_done) state_in = ST_PMUL;
         ST_PMUL: if (idx_ff == cnt_ff) state_in = ST_EMIT;
                  else if (mb_ff == 5'd24) state_in = ST_PDIV;
         ST_PDIV: begin
            state_in = ST_PADD;
            div_go = 1'b1;
            div_n = {1'b0, acc_ff} + {24'd0, root_ff[24:1]};
         end
         ST_PADD: if (div_done) state_in = (axis_ff) ? ST_EMIT : ST_PMUL;
         ST_EMIT: state_in = (idx_ff == cnt_ff) ? ST_IDLE : ST_PMUL;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 16'd384;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= (state_ff == ST_PADD && div_done && axis_ff) ||
                      (state_ff == ST_EMIT && idx_ff == cnt_ff);
         if (csr_we) step_ff <= csr_wdata;
         case (state_ff)
            ST_IDLE: if (start) begin
               sx_ff <= 25'(req_data.start_x); sy_ff <= 25'(req_data.start_y);
               tx_ff <= req_data.target_x; ty_ff <= req_data.target_y;
               dx_ff <= 25'(req_data.target_x) - 25'(req_data.start_x);
               dy_ff <= 25'(req_data.target_y) - 25'(req_data.start_y);
               k_ff <= '0; root_ff <= '0; rem_ff <= '0;
               rad_ff <= '0;
            end
            ST_SQRT: begin
               // load the radicand, then 25 digit steps
               if (k_ff == 5'd0)
                  rad_ff <= 50'($signed(dx_ff) * $signed(dx_ff))
                          + 50'($signed(dy_ff) * $signed(dy_ff));
               else begin
                  rad_ff <= {rad_ff[47:0], 2'b00};
                  if (!sq_trial[26]) begin
                     rem_ff <= sq_trial[25:0];
                     root_ff <= {root_ff[24:0], 1'b1};
                  end else begin
                     rem_ff <= {rem_ff[23:0], rad_ff[49:48]};
                     root_ff <= {root_ff[24:0], 1'b0};
                  end
               end
               k_ff <= k_ff + 5'd1;
            end
            ST_QUAD: begin
               ci_ff <= '0;
               if (dx_ff < 0) begin
                  if (dy_ff >= 0) begin
                     cx_ff <= 28'(dy_ff); cy_ff <= -28'(dx_ff);
                     cz_ff <= 20'(HALF_PI_Q16);
                  end else begin
                     cx_ff <= -28'(dy_ff); cy_ff <= 28'(dx_ff);
                     cz_ff <= -20'(HALF_PI_Q16);
                  end
               end else begin
                  cx_ff <= 28'(dx_ff); cy_ff <= 28'(dy_ff); cz_ff <= '0;
               end
            end
            ST_CORDIC: begin
               ci_ff <= ci_ff + 4'd1;
               if (cy_ff >= 0) begin
                  cx_ff <= cx_ff + ys; cy_ff <= cy_ff - xs;
                  cz_ff <= cz_ff + 20'(atan_q16(ci_ff));
               end else begin
                  cx_ff <= cx_ff - ys; cy_ff <= cy_ff + xs;
                  cz_ff <= cz_ff - 20'(atan_q16(ci_ff));
               end
            end
            ST_ROUND: begin
               hd_ff <= (dx_ff == 0 && dy_ff == 0) ? 16'sd0 : h_r[15:0];
               idx_ff <= '0; axis_ff <= 1'b0;
            end
            ST_CNT: begin
               if (step_ff == 16'd0) cnt_ff <= CMAX;
               else if (div_done)
                  cnt_ff <= (div_q > 48'(CMAX)) ? CMAX : div_q[CW-1:0];
               if (step_ff == 16'd0 || div_done) begin
                  mb_ff <= '0; acc_ff <= '0;
                  mcand_ff <= 47'(idx_ff) * 47'(step_ff);
                  mplr_ff <= 25'(absd);
               end
            end
            ST_PMUL: begin
               if (mplr_ff[0]) acc_ff <= acc_ff + mcand_ff;
               mcand_ff <= {mcand_ff[45:0], 1'b0};
               mplr_ff <= {1'b0, mplr_ff[24:1]};
               mb_ff <= mb_ff + 5'd1;
               neg_ff <= axis_ff ? dy_ff[24] : dx_ff[24];
            end
            ST_PADD: if (div_done) begin
               // zero distance reaches this state only with zero step, offsets stay zero
               if (!axis_ff) begin
                  ox_ff <= (root_ff == 0) ? 25'sd0 :
                           neg_ff ? -25'(div_q) : 25'(div_q);
                  axis_ff <= 1'b1;
                  mb_ff <= '0; acc_ff <= '0;
                  mcand_ff <= 47'(idx_ff) * 47'(step_ff);
                  mplr_ff <= dy_ff[24] ? -dy_ff : dy_ff;
               end else begin
                  rsp_data.point_x <= 24'(sx_ff + ox_ff);
                  rsp_data.point_y <= 24'(sy_ff + ((root_ff == 0) ? 25'sd0 :
                                      neg_ff ? -25'(div_q) : 25'(div_q)));
                  rsp_data.heading <= hd_ff;
                  rsp_data.is_last <= 1'b0;
               end
            end
            ST_EMIT: begin
               if (idx_ff == cnt_ff) begin
                  rsp_data.point_x <= tx_ff;
                  rsp_data.point_y <= ty_ff;
                  rsp_data.heading <= hd_ff;
                  rsp_data.is_last <= 1'b1;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
                  axis_ff <= 1'b0;
                  mb_ff <= '0; acc_ff <= '0;
                  mcand_ff <= 47'(idx_ff + 1'b1) * 47'(step_ff);
                  mplr_ff <= dx_ff[24] ? -dx_ff : dx_ff;
               end
            end
            default: ;
         endcase
      end
   end
endmodule

[hw/rtl/lwg_checker.sv]
// port-level checks of the waypoint generator
`include "line_waypoint_generator_macros.svh"
module lwg_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input lwg_pkg::rsp_type rsp_data
);
   import lwg_pkg::*;
   `LWG_ASSERT_IMP(a_rsp_busy, clock, reset, rsp_valid, busy || rsp_data.is_last)
   `LWG_ASSERT_IMP(a_last_idle, clock, reset, rsp_valid && rsp_data.is_last, !busy)
   `LWG_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   `LWG_ASSERT_IMP(a_head_rng, clock, reset, rsp_valid,
      rsp_data.heading <= 16'sd25736 && rsp_data.heading >= -16'sd25736)
endmodule

bind line_waypoint_generator lwg_checker u_lwg_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_data(rsp_data)
);
